// ===== rtl/dsp_pkg.sv =====
`timescale 1ns / 1ps
package dsp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_ARCS     = 4096;
  localparam int HEAP_DEPTH   = MAX_ARCS + 1;

  localparam int VW  = $clog2(MAX_VERTICES);   // vertex index
  localparam int CW  = VW + 1;                 // vertex count / predecessor
  localparam int LW  = $clog2(MAX_ARCS) + 1;   // arc link, empty marker fits
  localparam int AAW = $clog2(MAX_ARCS);       // arc store address
  localparam int HAW = $clog2(HEAP_DEPTH);     // heap index
  localparam int WW  = 16;                     // arc weight Q8.8
  localparam int DW  = 32;                     // distance Q24.8
  localparam int KW  = DW + VW;                // heap key {distance, vertex}
  localparam int VMW = CW + DW;                // vertex entry {prev, dist}
  localparam int AMW = LW + WW + VW;           // arc entry {link, weight, head}

  localparam logic [DW-1:0] INF_DIST   = '1;
  localparam logic [DW-1:0] SAT_DIST   = {{(DW-1){1'b1}}, 1'b0};
  localparam logic [CW-1:0] NO_PRED    = '1;
  localparam logic [LW-1:0] EMPTY_LINK = LW'(MAX_ARCS);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_VERT  = 2'd2;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_DISPATCH, S_ADD_WR, S_QUERY, S_RESP,
    S_SEED, S_POP0, S_POP1, S_POP2, S_SD_L, S_SD_R, S_SD_CMP,
    S_VISIT, S_VISIT2, S_ARC, S_ARC2, S_RELAX, S_SU, S_SU2
  } state_t;

  typedef enum logic [1:0] {SW_RESET, SW_CLEAR, SW_RUN} sweep_t;

  typedef struct packed {
    logic           we;
    logic [VW-1:0]  waddr;
    logic [VMW-1:0] wdata;
    logic [VW-1:0]  raddr;
  } vert_req_t;

  typedef struct packed {
    logic           we;
    logic [VW-1:0]  waddr;
    logic [LW-1:0]  wdata;
    logic [VW-1:0]  raddr;
  } head_req_t;

  typedef struct packed {
    logic           we;
    logic [AAW-1:0] waddr;
    logic [AMW-1:0] wdata;
    logic [AAW-1:0] raddr;
  } arc_req_t;

  typedef struct packed {
    logic           we;
    logic [HAW-1:0] waddr;
    logic [KW-1:0]  wdata;
    logic [HAW-1:0] raddr;
  } heap_req_t;

  typedef struct packed {
    logic          heap_empty;
    logic [LW-1:0] arc_fill;
  } dsp_stat_t;

endpackage

// ===== rtl/dsp_ram.sv =====
`timescale 1ns / 1ps
module dsp_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dsp_ctrl.sv =====
`timescale 1ns / 1ps
module dsp_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [dsp_pkg::CW-1:0]   cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [dsp_pkg::VW-1:0]   in_from,
  input  logic [dsp_pkg::VW-1:0]   in_to,
  input  logic [dsp_pkg::WW-1:0]   in_weight,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [dsp_pkg::DW-1:0]   out_dist,
  output logic [dsp_pkg::CW-1:0]   out_pred,
  output logic                     out_reach,
  output dsp_pkg::vert_req_t       vreq,
  input  logic [dsp_pkg::VMW-1:0]  vrdata,
  output dsp_pkg::head_req_t       hdreq,
  input  logic [dsp_pkg::LW-1:0]   hdrdata,
  output dsp_pkg::arc_req_t        areq,
  input  logic [dsp_pkg::AMW-1:0]  ardata,
  output dsp_pkg::heap_req_t       hpreq,
  input  logic [dsp_pkg::KW-1:0]   hprdata,
  output dsp_pkg::dsp_stat_t       stat
);
  import dsp_pkg::*;

  state_t state, state_next;
  sweep_t mode;

  logic [CW-1:0]  vcount;
  logic [CW-1:0]  n_live;

  // latched request
  logic [1:0]     cmd;
  logic [VW-1:0]  fv, tv;
  logic [WW-1:0]  wt;

  // staged result
  logic [1:0]     r_status;
  logic [DW-1:0]  r_dist;
  logic [CW-1:0]  r_pred;
  logic           r_reach;

  logic [VW-1:0]  sweep_cnt;
  logic [LW-1:0]  arc_fill;
  logic [HAW:0]   heap_fill;
  logic [HAW-1:0] pos;
  logic [KW-1:0]  hkey;
  logic [KW-1:0]  top;
  logic [KW-1:0]  lval;
  logic           r_ok;
  logic [LW-1:0]  arc_ptr;
  logic [LW-1:0]  arc_link;
  logic [VW-1:0]  arc_v;
  logic [DW-1:0]  nd;

  // derived terms
  logic           fv_bad, tv_bad;
  logic [HAW+1:0] lidx, ridx;
  logic [HAW-1:0] parent;
  logic [DW-1:0]  top_d;
  logic [VW-1:0]  top_u;
  logic [DW:0]    sum;
  logic [DW-1:0]  sum_sat;
  logic           l_lt, r_lt, pick_l, pick_r;
  logic [KW-1:0]  rcmp;

  always_comb begin
    if (vcount == '0) begin
      n_live = CW'(1);
    end else if (vcount > CW'(MAX_VERTICES)) begin
      n_live = CW'(MAX_VERTICES);
    end else begin
      n_live = vcount;
    end
  end

  assign fv_bad  = {1'b0, fv} >= n_live;
  assign tv_bad  = {1'b0, tv} >= n_live;
  assign lidx    = {1'b0, pos, 1'b1};
  assign ridx    = lidx + (HAW+2)'(1);
  assign parent  = (pos - HAW'(1)) >> 1;
  assign top_d   = top[KW-1:VW];
  assign top_u   = top[VW-1:0];
  assign sum     = {1'b0, top_d} + {{(DW+1-WW){1'b0}}, ardata[VW +: WW]};
  assign sum_sat = (sum > {1'b0, SAT_DIST}) ? SAT_DIST : sum[DW-1:0];

  // sift-down child selection, strict less keeps the parent on ties
  assign l_lt   = lval < hkey;
  assign pick_l = l_lt;
  assign rcmp   = pick_l ? lval : hkey;
  assign r_lt   = r_ok && (hprdata < rcmp);
  assign pick_r = r_lt;

  assign in_ready        = (state == S_IDLE);
  assign stat.heap_empty = (heap_fill == '0);
  assign stat.arc_fill   = arc_fill;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= CW'(MAX_VERTICES);
    end else if (cfg_we) begin
      vcount <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_cnt == VW'(MAX_VERTICES - 1)) begin
          unique case (mode)
            SW_RESET: state_next = S_IDLE;
            SW_CLEAR: state_next = S_RESP;
            SW_RUN:   state_next = S_SEED;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cmd)
          CMD_CLEAR: state_next = S_SWEEP;
          CMD_ADD: begin
            if (fv_bad || tv_bad || arc_fill >= LW'(MAX_ARCS)) state_next = S_RESP;
            else state_next = S_ADD_WR;
          end
          CMD_RUN:   state_next = fv_bad ? S_RESP : S_SWEEP;
          default:   state_next = fv_bad ? S_RESP : S_QUERY;
        endcase
      end
      S_ADD_WR:   state_next = S_RESP;
      S_QUERY:    state_next = S_RESP;
      S_RESP:     if (!out_valid || out_ready) state_next = S_IDLE;
      S_SEED:     state_next = S_POP0;
      S_POP0:     state_next = (heap_fill == '0) ? S_RESP : S_POP1;
      S_POP1:     state_next = S_POP2;
      S_POP2:     state_next = S_SD_L;
      S_SD_L:     state_next = (lidx < (HAW+2)'(heap_fill)) ? S_SD_R : S_VISIT;
      S_SD_R:     state_next = S_SD_CMP;
      S_SD_CMP:   state_next = (pick_l || pick_r) ? S_SD_L : S_VISIT;
      S_VISIT:    state_next = ({1'b0, top_u} >= n_live) ? S_POP0 : S_VISIT2;
      S_VISIT2:   state_next = (top_d > vrdata[DW-1:0]) ? S_POP0 : S_ARC;
      S_ARC:      state_next = arc_ptr[LW-1] ? S_POP0 : S_ARC2;
      S_ARC2: begin
        if ({1'b0, ardata[VW-1:0]} < n_live) state_next = S_RELAX;
        else state_next = S_ARC;
      end
      S_RELAX: begin
        if (nd < vrdata[DW-1:0] && heap_fill < (HAW+1)'(HEAP_DEPTH)) state_next = S_SU;
        else state_next = S_ARC;
      end
      S_SU:       state_next = (pos == '0) ? S_ARC : S_SU2;
      S_SU2:      state_next = (hprdata <= hkey) ? S_ARC : S_SU;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    vreq  = '0;
    hdreq = '0;
    areq  = '0;
    hpreq = '0;
    unique case (state)
      S_SWEEP: begin
        vreq.we     = 1'b1;
        vreq.waddr  = sweep_cnt;
        vreq.wdata  = {NO_PRED, INF_DIST};
        hdreq.we    = (mode != SW_RUN);
        hdreq.waddr = sweep_cnt;
        hdreq.wdata = EMPTY_LINK;
      end
      S_DISPATCH: begin
        hdreq.raddr = fv;
        vreq.raddr  = fv;
      end
      S_ADD_WR: begin
        areq.we     = 1'b1;
        areq.waddr  = arc_fill[AAW-1:0];
        areq.wdata  = {hdrdata, wt, tv};
        hdreq.we    = 1'b1;
        hdreq.waddr = fv;
        hdreq.wdata = arc_fill;
      end
      S_SEED: begin
        vreq.we     = 1'b1;
        vreq.waddr  = fv;
        vreq.wdata  = {NO_PRED, {DW{1'b0}}};
        hpreq.we    = 1'b1;
        hpreq.waddr = '0;
        hpreq.wdata = {{DW{1'b0}}, fv};
      end
      S_POP0: hpreq.raddr = '0;
      S_POP1: hpreq.raddr = HAW'(heap_fill - (HAW+1)'(1));
      S_SD_L: begin
        if (lidx < (HAW+2)'(heap_fill)) begin
          hpreq.raddr = lidx[HAW-1:0];
        end else begin
          hpreq.we    = 1'b1;
          hpreq.waddr = pos;
          hpreq.wdata = hkey;
        end
      end
      S_SD_R: hpreq.raddr = ridx[HAW-1:0];
      S_SD_CMP: begin
        hpreq.we    = 1'b1;
        hpreq.waddr = pos;
        hpreq.wdata = pick_r ? hprdata : (pick_l ? lval : hkey);
      end
      S_VISIT: begin
        vreq.raddr  = top_u;
        hdreq.raddr = top_u;
      end
      S_ARC:  areq.raddr = arc_ptr[AAW-1:0];
      S_ARC2: vreq.raddr = ardata[VW-1:0];
      S_RELAX: begin
        if (nd < vrdata[DW-1:0]) begin
          vreq.we    = 1'b1;
          vreq.waddr = arc_v;
          vreq.wdata = {1'b0, top_u, nd};
        end
      end
      S_SU: begin
        if (pos == '0) begin
          hpreq.we    = 1'b1;
          hpreq.waddr = '0;
          hpreq.wdata = hkey;
        end else begin
          hpreq.raddr = parent;
        end
      end
      S_SU2: begin
        hpreq.we    = 1'b1;
        hpreq.waddr = pos;
        hpreq.wdata = (hprdata <= hkey) ? hkey : hprdata;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      mode      <= SW_RESET;
      sweep_cnt <= '0;
      arc_fill  <= '0;
      heap_fill <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result register: load when free or draining, else clear on handoff
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: sweep_cnt <= sweep_cnt + VW'(1);
        S_DISPATCH: begin
          sweep_cnt <= '0;
          if (cmd == CMD_CLEAR) begin
            mode     <= SW_CLEAR;
            arc_fill <= '0;
          end else if (cmd == CMD_RUN) begin
            mode <= SW_RUN;
          end
        end
        S_ADD_WR: arc_fill  <= arc_fill + LW'(1);
        S_SEED:   heap_fill <= (HAW+1)'(1);
        S_POP1:   heap_fill <= heap_fill - (HAW+1)'(1);
        S_RELAX: begin
          if (nd < vrdata[DW-1:0] && heap_fill < (HAW+1)'(HEAP_DEPTH)) begin
            heap_fill <= heap_fill + (HAW+1)'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cmd <= in_cmd;
        fv  <= in_from;
        tv  <= in_to;
        wt  <= in_weight;
      end
      S_DISPATCH: begin
        r_pred  <= NO_PRED;
        r_reach <= 1'b0;
        if ((cmd == CMD_ADD) && (fv_bad || tv_bad)) begin
          r_status <= ST_BAD_VERT;
          r_dist   <= '0;
        end else if ((cmd == CMD_ADD) && arc_fill >= LW'(MAX_ARCS)) begin
          r_status <= ST_FULL;
          r_dist   <= '0;
        end else if ((cmd == CMD_RUN) && fv_bad) begin
          r_status <= ST_BAD_VERT;
          r_dist   <= '0;
        end else if ((cmd == CMD_QUERY) && fv_bad) begin
          r_status <= ST_BAD_VERT;
          r_dist   <= INF_DIST;
        end else begin
          r_status <= ST_OK;
          r_dist   <= '0;
        end
      end
      S_QUERY: begin
        r_dist  <= vrdata[DW-1:0];
        r_pred  <= vrdata[VMW-1:DW];
        r_reach <= (vrdata[DW-1:0] != INF_DIST);
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_status <= r_status;
          out_dist   <= r_dist;
          out_pred   <= r_pred;
          out_reach  <= r_reach;
        end
      end
      S_POP1: top <= hprdata;
      S_POP2: begin
        hkey <= hprdata;
        pos  <= '0;
      end
      S_SD_R: begin
        lval <= hprdata;
        r_ok <= ridx < (HAW+2)'(heap_fill);
      end
      S_SD_CMP: begin
        if (pick_r) pos <= ridx[HAW-1:0];
        else if (pick_l) pos <= lidx[HAW-1:0];
      end
      S_VISIT2: arc_ptr <= hdrdata;
      S_ARC2: begin
        arc_v    <= ardata[VW-1:0];
        arc_link <= ardata[AMW-1:VW+WW];
        nd       <= sum_sat;
        if ({1'b0, ardata[VW-1:0]} >= n_live) arc_ptr <= ardata[AMW-1:VW+WW];
      end
      S_RELAX: begin
        arc_ptr <= arc_link;
        hkey    <= {nd, arc_v};
        pos     <= heap_fill[HAW-1:0];
      end
      S_SU2: begin
        if (hprdata > hkey) pos <= parent;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/dijkstra_shortest_path_engine_top.sv =====
`timescale 1ns / 1ps
// Shortest path engine. Requests enter on the s_axis channel, one result per
// request leaves on m_axis. tuser carries the command in, the status out.
// Commands: clear graph, add arc (tail, head, Q8.8 weight), run from source,
// query vertex (distance Q24.8, predecessor, reachable).
// cfg_we / cfg_wdata set the vertex count; write it only while idle.
// Work per request:
//   add: a head memory read, then the arc write and the head write.
//   query: a vertex memory read.
//   clear: a wipe pass over the vertex memories.
//   run: a wipe of the distance and predecessor memory, then per heap pop a
//   root read, a last-entry read and a sift-down, per arc a read and a relax
//   step with a sift-up when the distance improves; the single read port of
//   the heap memory sets the pace. Requests are taken one at a time. A
// finished result sits in the output register while the next request is
// accepted and worked on; that request waits for the register only at its end if the receiver stalls.
// After reset the engine wipes its vertex memories with s_axis_tready low;
// configuration writes are taken during that wipe.
module dijkstra_shortest_path_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,       // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // from_vertex, to_vertex, arc_weight, zero pad
  input  logic [1:0]  s_axis_tuser,    // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // distance, predecessor, reachable, zero pad
  output logic [1:0]  m_axis_tuser     // status
);
  import dsp_pkg::*;

  vert_req_t  vreq;
  head_req_t  hdreq;
  arc_req_t   areq;
  heap_req_t  hpreq;
  dsp_stat_t  stat;
  logic [VMW-1:0] vrdata;
  logic [LW-1:0]  hdrdata;
  logic [AMW-1:0] ardata;
  logic [KW-1:0]  hprdata;
  logic [DW-1:0]  out_dist;
  logic [CW-1:0]  out_pred;
  logic           out_reach;

  assign m_axis_tdata = {4'b0, out_reach, out_pred, out_dist};

  dsp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_from    (s_axis_tdata[9:0]),
    .in_to      (s_axis_tdata[19:10]),
    .in_weight  (s_axis_tdata[35:20]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_dist   (out_dist),
    .out_pred   (out_pred),
    .out_reach  (out_reach),
    .vreq       (vreq),
    .vrdata     (vrdata),
    .hdreq      (hdreq),
    .hdrdata    (hdrdata),
    .areq       (areq),
    .ardata     (ardata),
    .hpreq      (hpreq),
    .hprdata    (hprdata),
    .stat       (stat)
  );

  // distance and predecessor per vertex
  dsp_ram #(.W(VMW), .D(MAX_VERTICES)) u_vert (
    .clk(clk), .we(vreq.we), .waddr(vreq.waddr), .wdata(vreq.wdata),
    .raddr(vreq.raddr), .rdata(vrdata)
  );

  // arc list heads
  dsp_ram #(.W(LW), .D(MAX_VERTICES)) u_head (
    .clk(clk), .we(hdreq.we), .waddr(hdreq.waddr), .wdata(hdreq.wdata),
    .raddr(hdreq.raddr), .rdata(hdrdata)
  );

  // arc store
  dsp_ram #(.W(AMW), .D(MAX_ARCS)) u_arc (
    .clk(clk), .we(areq.we), .waddr(areq.waddr), .wdata(areq.wdata),
    .raddr(areq.raddr), .rdata(ardata)
  );

  // binary min-heap
  dsp_ram #(.W(KW), .D(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(hpreq.we), .waddr(hpreq.waddr), .wdata(hpreq.wdata),
    .raddr(hpreq.raddr), .rdata(hprdata)
  );

  // a new request never finds leftover heap entries
  a_heap_empty_at_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> stat.heap_empty)
    else $error("heap not empty at request accept");

  // arc fill never passes the store depth
  a_arc_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stat.arc_fill <= LW'(MAX_ARCS))
    else $error("arc fill beyond store depth");

  // heap writes stay inside the heap
  a_heap_write_bound: assert property (@(posedge clk) disable iff (rst)
    hpreq.we |-> (hpreq.waddr < HAW'(HEAP_DEPTH)))
    else $error("heap write out of range");

endmodule
